// ===== rtl/cci_pkg.sv =====
package cci_pkg;

    // Default depth of the sample chain.
    localparam int MAX_WINDOW_DEF = 64;

    // Reset value of the window length register.
    localparam logic [6:0] WINDOW_LENGTH_RST = 7'd20;

    // Width of the shared divider operands.
    localparam int DIV_W = 64;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MEAN,
        ST_DEV,
        ST_DEVDIV,
        ST_QUOT,
        ST_OUT
    } state_t;

    // Per-cycle control for every cell in the chain.
    typedef struct packed {
        logic shift;   // append: take the neighbor toward the newest end
        logic rotate;  // walk: take the neighbor toward the oldest end
        logic load;    // replace: take the input sample directly
    } cell_ctrl_t;

endpackage

// ===== rtl/cci_cell.sv =====
module cci_cell (
    input  logic                aclk,
    input  cci_pkg::cell_ctrl_t ctrl,
    input  logic signed [31:0]  shift_in,
    input  logic signed [31:0]  rot_in,
    output logic signed [31:0]  data_out
);

    logic signed [31:0] data_reg;

    // One stored sample, handed to a neighbor on a shift or a rotation.
    always_ff @(posedge aclk) begin
        if (ctrl.shift || ctrl.load) begin
            data_reg <= shift_in;
        end else if (ctrl.rotate) begin
            data_reg <= rot_in;
        end
    end

    assign data_out = data_reg;

endmodule

// ===== rtl/cci_div.sv =====
module cci_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [cci_pkg::DIV_W-1:0] num,
    input  logic signed [cci_pkg::DIV_W-1:0] den,
    output logic                             done,
    output logic signed [cci_pkg::DIV_W-1:0] quot
);

    localparam int W  = cci_pkg::DIV_W;
    localparam int CW = $clog2(W);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic          neg_reg;
    logic [W-1:0]  a_reg;
    logic [W-1:0]  b_reg;
    logic [W-1:0]  rem_reg;
    logic [W:0]    rem_sh;
    logic [W:0]    rem_sub;
    logic          fits;

    // One restoring step: shift in the next dividend bit and try the divisor.
    assign rem_sh  = {rem_reg, a_reg[W-1]};
    assign rem_sub = rem_sh - {1'b0, b_reg};
    assign fits    = (rem_sh >= {1'b0, b_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Magnitudes are divided; the sign is applied at the end (truncation toward zero).
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= num[W-1] ^ den[W-1];
            a_reg   <= num[W-1] ? W'(-num) : W'(num);
            b_reg   <= den[W-1] ? W'(-den) : W'(den);
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? rem_sub[W-1:0] : rem_sh[W-1:0];
            a_reg   <= {a_reg[W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -signed'(a_reg) : signed'(a_reg);

endmodule

// ===== rtl/commodity_channel_index.sv =====
// Commodity channel index over a sliding window of signed Q16.16 samples held in a
// chain of MAX_WINDOW cells, newest sample at the head. An item with a missing
// sample has its result offered in the cycle after it is taken. An item that leaves
// fewer stored samples than the window length is answered after one full walk of
// the chain. Any other item is answered once the chain has been rotated once in
// full to form the sum and once more for the absolute deviation, and a shared
// one-bit-per-cycle divider has given the mean, the mean deviation and, when that
// deviation is not zero, the final quotient. Items are handled one at a time;
// the next item is taken in the cycle after the result has been handed off.
module commodity_channel_index #(
    parameter int MAX_WINDOW = cci_pkg::MAX_WINDOW_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic signed [31:0] s_sample,
    input  logic               s_sample_missing,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_index_value,
    output logic               m_value_valid,
    input  logic               cfg_wr_en,
    input  logic [6:0]         cfg_wr_data
);

    localparam int W     = cci_pkg::DIV_W;
    localparam int NW    = $clog2(MAX_WINDOW + 1);
    localparam int LW    = (NW > 7) ? NW : 7;
    localparam int ACC_W = 34 + $clog2(MAX_WINDOW);

    cci_pkg::state_t     state_reg, state_next;
    cci_pkg::cell_ctrl_t cell_ctrl;

    logic [6:0]              wlen_reg;
    logic [NW-1:0]           fill_reg;
    logic [NW-1:0]           cnt_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [31:0]      sample_reg;
    logic signed [31:0]      mean_reg;
    logic signed [31:0]      res_value_reg;
    logic                    res_valid_reg;

    logic signed [31:0]      cell_data [MAX_WINDOW];
    logic [NW-1:0]           n_eff;
    logic                    in_acc;
    logic                    window_upd;
    logic                    append;
    logic                    last_step;
    logic                    full;
    logic signed [ACC_W-1:0] head_ext;
    logic signed [ACC_W-1:0] dev_d;
    logic signed [ACC_W-1:0] acc_add;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [32:0]      diff;
    logic signed [40:0]      diff_x200;
    logic signed [W-1:0]     quot_num;
    logic [ACC_W+1:0]        den3;
    logic                    div_start;
    logic                    div_done;
    logic signed [W-1:0]     div_num;
    logic signed [W-1:0]     div_den;
    logic signed [W-1:0]     div_q;
    logic signed [31:0]      sat_q;

    // Effective length: zero acts as one, anything above the depth as the depth.
    always_comb begin
        if (wlen_reg == 7'd0) begin
            n_eff = NW'(1);
        end else if (LW'(wlen_reg) > LW'(MAX_WINDOW)) begin
            n_eff = NW'(MAX_WINDOW);
        end else begin
            n_eff = NW'(wlen_reg);
        end
    end

    assign in_acc     = s_valid && s_ready;
    assign window_upd = in_acc && !s_sample_missing;
    assign append     = !s_cmd || (fill_reg == '0);
    assign last_step  = (cnt_reg == NW'(MAX_WINDOW - 1));
    assign full       = (fill_reg >= n_eff);

    // Chain of cells: appends shift toward the tail, walks rotate toward the head.
    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        cci_pkg::cell_ctrl_t ctrl_i;
        logic signed [31:0]  shift_src;

        always_comb begin
            ctrl_i      = cell_ctrl;
            ctrl_i.load = (i == 0) ? cell_ctrl.load : 1'b0;
        end

        if (i == 0) begin : g_head
            assign shift_src = s_sample;
        end else begin : g_body
            assign shift_src = cell_data[i-1];
        end

        cci_cell u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl_i),
            .shift_in (shift_src),
            .rot_in   (cell_data[(i + 1) % MAX_WINDOW]),
            .data_out (cell_data[i])
        );
    end

    // Accumulation of the head cell: plain sum, then absolute deviation from the mean.
    assign head_ext = ACC_W'(cell_data[0]);
    assign dev_d    = head_ext - ACC_W'(mean_reg);
    always_comb begin
        acc_add = '0;
        if (cnt_reg < n_eff) begin
            if (state_reg == cci_pkg::ST_SUM) begin
                acc_add = head_ext;
            end else begin
                acc_add = (dev_d < 0) ? -dev_d : dev_d;
            end
        end
    end
    assign acc_next = acc_reg + acc_add;

    // Quotient operands: (sample - mean) * 200 * 65536 over 3 * deviation.
    assign diff      = 33'(sample_reg) - 33'(mean_reg);
    assign diff_x200 = (41'(diff) <<< 7) + (41'(diff) <<< 6) + (41'(diff) <<< 3);
    assign quot_num  = W'(diff_x200) <<< 16;
    assign den3      = (ACC_W+2)'(div_q[ACC_W-1:0])
                     + ((ACC_W+2)'(div_q[ACC_W-1:0]) << 1);

    // Divider operand selection by phase.
    always_comb begin
        if (state_reg == cci_pkg::ST_DEVDIV) begin
            div_num = quot_num;
            div_den = W'(den3);
        end else begin
            div_num = W'(acc_next);
            div_den = W'(n_eff);
        end
    end

    cci_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_q)
    );

    // Clamp the final quotient to 32 bits.
    always_comb begin
        if (div_q > W'(64'sd2147483647)) begin
            sat_q = 32'sh7fffffff;
        end else if (div_q < -W'(64'sd2147483648)) begin
            sat_q = 32'sh80000000;
        end else begin
            sat_q = div_q[31:0];
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cci_pkg::ST_IDLE: begin
                if (in_acc) begin
                    state_next = s_sample_missing ? cci_pkg::ST_OUT : cci_pkg::ST_SUM;
                end
            end
            cci_pkg::ST_SUM: begin
                if (last_step) begin
                    state_next = full ? cci_pkg::ST_MEAN : cci_pkg::ST_OUT;
                end
            end
            cci_pkg::ST_MEAN: begin
                if (div_done) begin
                    state_next = cci_pkg::ST_DEV;
                end
            end
            cci_pkg::ST_DEV: begin
                if (last_step) begin
                    state_next = cci_pkg::ST_DEVDIV;
                end
            end
            cci_pkg::ST_DEVDIV: begin
                if (div_done) begin
                    state_next = (div_q == '0) ? cci_pkg::ST_OUT : cci_pkg::ST_QUOT;
                end
            end
            cci_pkg::ST_QUOT: begin
                if (div_done) begin
                    state_next = cci_pkg::ST_OUT;
                end
            end
            cci_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = cci_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cci_pkg::ST_IDLE;
            end
        endcase
    end

    // Output and control decode.
    always_comb begin
        s_ready          = 1'b0;
        m_valid          = 1'b0;
        div_start        = 1'b0;
        cell_ctrl.shift  = 1'b0;
        cell_ctrl.rotate = 1'b0;
        cell_ctrl.load   = 1'b0;
        case (state_reg)
            cci_pkg::ST_IDLE: begin
                s_ready         = 1'b1;
                cell_ctrl.shift = window_upd && append;
                cell_ctrl.load  = window_upd && !append;
            end
            cci_pkg::ST_SUM: begin
                cell_ctrl.rotate = 1'b1;
                div_start        = last_step && full;
            end
            cci_pkg::ST_DEV: begin
                cell_ctrl.rotate = 1'b1;
                div_start        = last_step;
            end
            cci_pkg::ST_DEVDIV: begin
                div_start = div_done && (div_q != '0);
            end
            cci_pkg::ST_OUT: begin
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cci_pkg::ST_IDLE;
            wlen_reg  <= cci_pkg::WINDOW_LENGTH_RST;
            fill_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                wlen_reg <= cfg_wr_data;
            end
            if (window_upd && append && (fill_reg != NW'(MAX_WINDOW))) begin
                fill_reg <= fill_reg + 1'b1;
            end
            if ((state_reg == cci_pkg::ST_SUM) || (state_reg == cci_pkg::ST_DEV)) begin
                cnt_reg <= last_step ? '0 : cnt_reg + 1'b1;
            end else begin
                cnt_reg <= '0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            cci_pkg::ST_IDLE: begin
                acc_reg       <= '0;
                sample_reg    <= s_sample;
                res_value_reg <= '0;
                res_valid_reg <= 1'b0;
            end
            cci_pkg::ST_SUM: begin
                acc_reg <= acc_next;
            end
            cci_pkg::ST_MEAN: begin
                acc_reg <= '0;
                if (div_done) begin
                    mean_reg <= div_q[31:0];
                end
            end
            cci_pkg::ST_DEV: begin
                acc_reg <= acc_next;
            end
            cci_pkg::ST_DEVDIV: begin
                if (div_done) begin
                    res_valid_reg <= 1'b1;
                    res_value_reg <= '0;
                end
            end
            cci_pkg::ST_QUOT: begin
                if (div_done) begin
                    res_value_reg <= sat_q;
                end
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign m_index_value = res_value_reg;
    assign m_value_valid = res_valid_reg;

endmodule

// ===== rtl/cci_checker.sv =====
module cci_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_sample_missing,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_index_value,
    input logic        m_value_valid
);

    // A pending result is not withdrawn.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result withdrawn before it was taken");

    // An unavailable result carries a zero index.
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_value_valid |-> m_index_value == 32'd0)
        else $error("unavailable result with nonzero index");

    // Only one item is in flight: no new item while a result waits.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while a result is pending");

    // A missing sample is answered on the next cycle as not available.
    a_missing: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_sample_missing |=> m_valid && !m_value_valid)
        else $error("missing sample not answered at once");

endmodule

bind commodity_channel_index cci_checker u_cci_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_sample_missing (s_sample_missing),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_index_value    (m_index_value),
    .m_value_valid    (m_value_valid)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int DEPTH = cci_pkg::MAX_WINDOW_DEF;
    localparam int IDLE_LIMIT = 20000;
    localparam int STORE_DEPTH = 1024;
    localparam int HOLD_CYCLES = 3000;

    typedef struct packed {
        logic        cmd;
        logic [31:0] sample;
        logic        missing;
    } cci_item_t;

    typedef struct packed {
        logic [31:0] index_value;
        logic        value_valid;
    } cci_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_cmd = 1'b0;
    logic signed [31:0] s_sample = '0;
    logic s_sample_missing = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_index_value;
    logic m_value_valid;
    logic cfg_wr_en = 1'b0;
    logic [6:0] cfg_wr_data = '0;

    // Stimulus and expectation stores, each a ring with its own write and read count.
    cci_item_t   pending_items[STORE_DEPTH];
    cci_result_t expected_index[STORE_DEPTH];
    int pend_wr = 0;
    int pend_rd = 0;
    int exp_wr = 0;
    int exp_rd = 0;

    // Predictor state.
    logic signed [31:0] pred_window[DEPTH] = '{default: '0};
    int unsigned pred_fill = 0;
    int unsigned pred_newest = 0;
    logic [6:0]  pred_length = cci_pkg::WINDOW_LENGTH_RST;

    int mismatch_count = 0;
    int idle_cycles = 0;
    int send_idle_pct = 20;
    int recv_idle_pct = 75;
    int recv_hold = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    commodity_channel_index u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_sample(s_sample),
        .s_sample_missing(s_sample_missing),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_index_value(m_index_value),
        .m_value_valid(m_value_valid),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #10 aclk = ~aclk;

    // Predict the channel index produced by one item and update the window.
    function automatic cci_result_t predict_index(cci_item_t it);
        cci_result_t r;
        int unsigned n;
        longint sum, mean, dev_sum, dev, d, q;
        r = '0;
        sum = 0;
        dev_sum = 0;
        if (it.missing) return r;
        if (it.cmd && pred_fill != 0) begin
            pred_window[pred_newest] = it.sample;
        end else begin
            pred_newest = (pred_fill == 0) ? 0 : (pred_newest + 1) % DEPTH;
            pred_window[pred_newest] = it.sample;
            if (pred_fill < DEPTH) pred_fill++;
        end
        n = (pred_length == 0) ? 1 : (pred_length > DEPTH) ? DEPTH : pred_length;
        if (pred_fill < n) return r;
        for (int k = 0; k < n; k++)
            sum += longint'(pred_window[(pred_newest + DEPTH - k) % DEPTH]);
        mean = sum / longint'(n);
        for (int k = 0; k < n; k++) begin
            d = longint'(pred_window[(pred_newest + DEPTH - k) % DEPTH]) - mean;
            dev_sum += (d < 0) ? -d : d;
        end
        dev = dev_sum / longint'(n);
        r.value_valid = 1'b1;
        if (dev == 0) return r;
        q = ((longint'($signed(it.sample)) - mean) * 13107200) / (dev * 3);
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        r.index_value = q[31:0];
        return r;
    endfunction

    // Driver: offers queued items, idling at random between them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pend_wr != pend_rd && $urandom_range(99) >= send_idle_pct) begin
                cci_item_t it;
                it = pending_items[pend_rd % STORE_DEPTH];
                pend_rd <= pend_rd + 1;
                expected_index[exp_wr % STORE_DEPTH] <= predict_index(it);
                exp_wr <= exp_wr + 1;
                s_valid <= 1'b1;
                s_cmd <= it.cmd;
                s_sample <= it.sample;
                s_sample_missing <= it.missing;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver ready, with one long hold-off counted here once it is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            recv_hold <= recv_hold + 1;
            if (recv_hold >= HOLD_CYCLES - 1)
                hold_done <= 1'b1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: compares each result with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (exp_wr == exp_rd) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected item: index %0d valid %0b",
                             m_index_value, m_value_valid);
            end else begin
                cci_result_t e;
                e = expected_index[exp_rd % STORE_DEPTH];
                exp_rd <= exp_rd + 1;
                if (e.index_value !== m_index_value || e.value_valid !== m_value_valid) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected index %0d valid %0b, got %0d valid %0b",
                                 $signed(e.index_value), e.value_valid,
                                 m_index_value, m_value_valid);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic add_item(logic cmd, logic [31:0] value, logic missing);
        cci_item_t it;
        it.cmd = cmd;
        it.sample = value;
        it.missing = missing;
        pending_items[pend_wr % STORE_DEPTH] = it;
        pend_wr++;
    endtask

    // Random samples: mostly small around a level, sometimes full range.
    task automatic add_random(int count);
        logic [31:0] v;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(3))
                0: v = $urandom;
                1: v = {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
                2: v = 32'($urandom_range(100)) << 16;
                default: v = 32'h0001_0000 + $urandom_range(255);
            endcase
            add_item($urandom_range(3) == 0, v, $urandom_range(9) == 0);
        end
    endtask

    task automatic drain();
        while (pend_wr != pend_rd || s_valid || exp_wr != exp_rd)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_length(logic [6:0] len);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= len;
        pred_length = len;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: missing on empty, replace on empty, extremes, flat window.
        write_length(7'd3);
        add_item(1'b0, 32'h7FFF_FFFF, 1'b1);
        add_item(1'b1, 32'h0001_0000, 1'b1);
        add_item(1'b1, 32'h0001_0000, 1'b0);
        add_item(1'b0, 32'h0001_0000, 1'b0);
        add_item(1'b0, 32'h0001_0000, 1'b0);
        add_item(1'b0, 32'h8000_0000, 1'b0);
        add_item(1'b0, 32'h7FFF_FFFF, 1'b0);
        add_item(1'b1, 32'h8000_0000, 1'b0);
        add_item(1'b1, 32'hFFFF_FFFF, 1'b0);
        add_item(1'b0, 32'h0000_0000, 1'b0);
        add_item(1'b0, 32'h0000_0001, 1'b0);
        add_item(1'b0, 32'h0000_0000, 1'b0);
        add_item(1'b0, 32'h7FFF_FFFF, 1'b0);
        add_item(1'b0, 32'h5555_5555, 1'b1);
        drain();
        write_length(7'd1);
        add_item(1'b0, 32'h1234_5678, 1'b0);
        add_item(1'b1, 32'hAAAA_AAAA, 1'b0);
        drain();
        // An out-of-range length of zero.
        write_length(7'd0);
        add_random(3);
        drain();

        // Receiver holds off long while the sender keeps offering.
        write_length(7'd127);
        hold_req = 1'b1;
        add_random(70);
        drain();

        write_length(7'd64);
        add_random(80);
        drain();
        write_length(cci_pkg::WINDOW_LENGTH_RST);
        add_random(90);
        drain();

        send_idle_pct = 75;
        recv_idle_pct = 20;
        write_length(7'd5);
        add_random(90);
        drain();
        write_length(7'd2);
        add_random(60);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_length(7'd9);
        add_random(70);
        drain();
        write_length(7'd33);
        add_random(70);
        drain();

        if (mismatch_count == 0 && exp_wr == exp_rd) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cci_pkg.sv
rtl/cci_cell.sv
rtl/cci_div.sv
rtl/commodity_channel_index.sv
rtl/cci_checker.sv
tb/sv/testbench.sv
